// ===== sv/suffix_array_lcp_builder_assert.svh =====
// Assertion macros for the suffix array and LCP builder.
`ifndef SUFFIX_ARRAY_LCP_BUILDER_ASSERT_SVH
`define SUFFIX_ARRAY_LCP_BUILDER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define SALB_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("salb assertion failed");
// Next-cycle implication.
`define SALB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("salb assertion failed");
`else
`define SALB_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define SALB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/salb_pkg.sv =====
// Shared types and command codes of the suffix array and LCP builder.
package salb_pkg;

    localparam int FUNC_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int RANK_W  = 10;
    localparam int POS_W   = 10;
    localparam int LEN_W   = 11;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_BUILD  = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] text_byte;
        logic [RANK_W-1:0] rank_index;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0] suffix_pos;
        logic [LEN_W-1:0] lcp_len;
        logic [LEN_W-1:0] text_count;
        logic             overflow;
        logic             bad_index;
    } out_item_t;

    // Datapath commands issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_APPEND,
        OP_READ,
        OP_READ_OUT,
        OP_BUILD_START,
        OP_INIT_STEP,
        OP_PASS_START,
        OP_RUN_START,
        OP_RUN_SETUP,
        OP_RUN_NEXT,
        OP_PASS_NEXT,
        OP_RD_I,
        OP_RD_J,
        OP_LATCH_X_RD_J,
        OP_LATCH_Y,
        OP_C_INC,
        OP_WR_X,
        OP_WR_Y,
        OP_CP_I,
        OP_CP_J,
        OP_LCP_START,
        OP_LCP_ZERO,
        OP_RD_PREV,
        OP_LATCH_X_RD_CUR,
        OP_LCP_WR,
        OP_BUILD_DONE
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic k_done;
        logic k_zero;
        logic w_done;
        logic lo_done;
        logic i_end;
        logic j_end;
        logic x_end;
        logic y_end;
        logic x_lt;
        logic x_ne;
    } status_t;

endpackage

// ===== sv/suffix_array_lcp_builder.sv =====
// Suffix array and LCP array builder, top level.
// Append and unused codes: no result, one request per cycle unless a result is stalled.
// Read: the stores are read, then the result is registered. Build: an init step per
// rank, then ceil(log2 n) merge passes that compare or copy ranks and an LCP pass, with
// suffixes compared byte by byte; input waits until the build result is posted and taken.
// Reset (synchronous, aresetn low) clears length, overflow and built flags.
module suffix_array_lcp_builder #(
    parameter int TEXT_DEPTH = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  salb_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output salb_pkg::out_item_t m_data
);
    salb_pkg::cmd_t    cmd;
    salb_pkg::status_t st;

    salb_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_func(s_data.func), .st(st), .cmd(cmd)
    );

    salb_dp #(.TEXT_DEPTH(TEXT_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .st(st), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule

// ===== sv/salb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module salb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/salb_ctrl.sv =====
// Controller state machine: sequences append, read and the sort/LCP build.
module salb_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  salb_pkg::status_t  st,
    output salb_pkg::cmd_t     cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_RD_WAIT, S_INIT, S_PASS_CHK, S_RUN_CHK, S_MRG_CHK, S_FETCH_J,
        S_CMP_START, S_CMP_RD, S_CMP_EV, S_CP_I, S_CP_J, S_LCP_CHK, S_LCP_B,
        S_LCP_C, S_LCP_RD, S_LCP_EV, S_DONE
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE) && st.out_free;

    // Next state and command
    always_comb begin
        state_next = state_reg;
        cmd.op     = salb_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    unique case (salb_pkg::func_t'(s_func))
                        salb_pkg::FUNC_APPEND: cmd.op = salb_pkg::OP_APPEND;
                        salb_pkg::FUNC_BUILD: begin
                            cmd.op     = salb_pkg::OP_BUILD_START;
                            state_next = S_INIT;
                        end
                        salb_pkg::FUNC_READ: begin
                            cmd.op     = salb_pkg::OP_READ;
                            state_next = S_RD_WAIT;
                        end
                        salb_pkg::FUNC_NOP: cmd.op = salb_pkg::OP_NONE;
                    endcase
                end
            end
            S_RD_WAIT: begin
                cmd.op     = salb_pkg::OP_READ_OUT;
                state_next = S_IDLE;
            end
            S_INIT: begin
                if (st.k_done) begin
                    cmd.op     = salb_pkg::OP_PASS_START;
                    state_next = S_PASS_CHK;
                end else begin
                    cmd.op = salb_pkg::OP_INIT_STEP;
                end
            end
            S_PASS_CHK: begin
                if (st.w_done) begin
                    cmd.op     = salb_pkg::OP_LCP_START;
                    state_next = S_LCP_CHK;
                end else begin
                    cmd.op     = salb_pkg::OP_RUN_START;
                    state_next = S_RUN_CHK;
                end
            end
            S_RUN_CHK: begin
                if (st.lo_done) begin
                    cmd.op     = salb_pkg::OP_PASS_NEXT;
                    state_next = S_PASS_CHK;
                end else begin
                    cmd.op     = salb_pkg::OP_RUN_SETUP;
                    state_next = S_MRG_CHK;
                end
            end
            S_MRG_CHK: begin
                priority if (st.i_end && st.j_end) begin
                    cmd.op     = salb_pkg::OP_RUN_NEXT;
                    state_next = S_RUN_CHK;
                end else if (st.i_end) begin
                    cmd.op     = salb_pkg::OP_RD_J;
                    state_next = S_CP_J;
                end else if (st.j_end) begin
                    cmd.op     = salb_pkg::OP_RD_I;
                    state_next = S_CP_I;
                end else begin
                    cmd.op     = salb_pkg::OP_RD_I;
                    state_next = S_FETCH_J;
                end
            end
            S_FETCH_J: begin
                cmd.op     = salb_pkg::OP_LATCH_X_RD_J;
                state_next = S_CMP_START;
            end
            S_CMP_START: begin
                cmd.op     = salb_pkg::OP_LATCH_Y;
                state_next = S_CMP_RD;
            end
            S_CMP_RD: state_next = S_CMP_EV;
            S_CMP_EV: begin
                // shorter suffix first, else first differing byte decides
                priority if (st.x_end) begin
                    cmd.op     = salb_pkg::OP_WR_X;
                    state_next = S_MRG_CHK;
                end else if (st.y_end) begin
                    cmd.op     = salb_pkg::OP_WR_Y;
                    state_next = S_MRG_CHK;
                end else if (st.x_ne) begin
                    cmd.op     = st.x_lt ? salb_pkg::OP_WR_X : salb_pkg::OP_WR_Y;
                    state_next = S_MRG_CHK;
                end else begin
                    cmd.op     = salb_pkg::OP_C_INC;
                    state_next = S_CMP_RD;
                end
            end
            S_CP_I: begin
                cmd.op     = salb_pkg::OP_CP_I;
                state_next = S_MRG_CHK;
            end
            S_CP_J: begin
                cmd.op     = salb_pkg::OP_CP_J;
                state_next = S_MRG_CHK;
            end
            S_LCP_CHK: begin
                priority if (st.k_done) begin
                    state_next = S_DONE;
                end else if (st.k_zero) begin
                    cmd.op = salb_pkg::OP_LCP_ZERO;
                end else begin
                    cmd.op     = salb_pkg::OP_RD_PREV;
                    state_next = S_LCP_B;
                end
            end
            S_LCP_B: begin
                cmd.op     = salb_pkg::OP_LATCH_X_RD_CUR;
                state_next = S_LCP_C;
            end
            S_LCP_C: begin
                cmd.op     = salb_pkg::OP_LATCH_Y;
                state_next = S_LCP_RD;
            end
            S_LCP_RD: state_next = S_LCP_EV;
            S_LCP_EV: begin
                if (st.x_end || st.y_end || st.x_ne) begin
                    cmd.op     = salb_pkg::OP_LCP_WR;
                    state_next = S_LCP_CHK;
                end else begin
                    cmd.op     = salb_pkg::OP_C_INC;
                    state_next = S_LCP_RD;
                end
            end
            S_DONE: begin
                cmd.op     = salb_pkg::OP_BUILD_DONE;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

// ===== sv/salb_dp.sv =====
// Datapath: text and rank stores, merge/LCP registers and the result register.
`include "suffix_array_lcp_builder_assert.svh"
module salb_dp #(
    parameter int TEXT_DEPTH = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  salb_pkg::cmd_t      cmd,
    output salb_pkg::status_t   st,
    input  salb_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output salb_pkg::out_item_t m_data
);
    localparam int AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int LW = $clog2(TEXT_DEPTH + 1);
    localparam int SW = LW + 2;
    localparam int CW = (LW > salb_pkg::RANK_W) ? LW : salb_pkg::RANK_W;

    salb_pkg::op_t op;
    assign op = cmd.op;

    logic [LW-1:0] n_reg, k_reg, i_reg, j_reg, lo_reg, mid_reg, hi_reg, c_reg;
    logic [SW-1:0] width_reg;
    logic [AW-1:0] x_reg, y_reg;
    logic          ovf_reg, built_reg, sel_reg, bad_reg, m_valid_reg;
    salb_pkg::out_item_t out_reg;

    logic [AW-1:0] rank_raddr, rank_waddr, rank_wdata;
    logic [AW-1:0] ra_rdata, rb_rdata, src_rdata;
    logic          rank_we, rank_to_src, tgt_b;
    logic [LW-1:0] lcp_rdata, lcp_wdata;
    logic [AW-1:0] lcp_waddr;
    logic          lcp_we;
    logic [7:0]    tx, ty;
    logic [SW-1:0] x_sum, y_sum, mid_sum, hi_sum;
    logic          txt_we;

    // Text store, mirrored for two reads per cycle
    assign txt_we = (op == salb_pkg::OP_APPEND) && (SW'(n_reg) < SW'(TEXT_DEPTH));
    assign x_sum  = SW'(x_reg) + SW'(c_reg);
    assign y_sum  = SW'(y_reg) + SW'(c_reg);

    salb_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_txt_x (
        .aclk(aclk), .we(txt_we), .waddr(AW'(n_reg)), .wdata(s_data.text_byte),
        .raddr(AW'(x_sum)), .rdata(tx)
    );
    salb_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_txt_y (
        .aclk(aclk), .we(txt_we), .waddr(AW'(n_reg)), .wdata(s_data.text_byte),
        .raddr(AW'(y_sum)), .rdata(ty)
    );

    // Rank buffers: sel picks the source run buffer, writes go to source or dest
    always_comb begin
        rank_raddr  = '0;
        rank_we     = 1'b0;
        rank_to_src = 1'b0;
        rank_wdata  = x_reg;
        lcp_we      = 1'b0;
        lcp_wdata   = c_reg;
        unique case (op)
            salb_pkg::OP_READ:            rank_raddr = AW'(s_data.rank_index);
            salb_pkg::OP_RD_I:            rank_raddr = AW'(i_reg);
            salb_pkg::OP_RD_J,
            salb_pkg::OP_LATCH_X_RD_J:    rank_raddr = AW'(j_reg);
            salb_pkg::OP_RD_PREV:         rank_raddr = AW'(k_reg - LW'(1));
            salb_pkg::OP_LATCH_X_RD_CUR:  rank_raddr = AW'(k_reg);
            salb_pkg::OP_INIT_STEP: begin
                rank_we     = 1'b1;
                rank_to_src = 1'b1;
                rank_wdata  = AW'(k_reg);
            end
            salb_pkg::OP_WR_X: rank_we = 1'b1;
            salb_pkg::OP_WR_Y: begin
                rank_we    = 1'b1;
                rank_wdata = y_reg;
            end
            salb_pkg::OP_CP_I, salb_pkg::OP_CP_J: begin
                rank_we    = 1'b1;
                rank_wdata = src_rdata;
            end
            salb_pkg::OP_LCP_ZERO: begin
                lcp_we    = 1'b1;
                lcp_wdata = '0;
            end
            salb_pkg::OP_LCP_WR: lcp_we = 1'b1;
            default: rank_raddr = '0;
        endcase
    end

    assign rank_waddr = AW'(k_reg);
    assign lcp_waddr  = AW'(k_reg);
    assign tgt_b      = sel_reg ^ ~rank_to_src;
    assign src_rdata  = sel_reg ? rb_rdata : ra_rdata;

    salb_ram #(.WIDTH(AW), .DEPTH(TEXT_DEPTH)) u_rank_a (
        .aclk(aclk), .we(rank_we && !tgt_b), .waddr(rank_waddr), .wdata(rank_wdata),
        .raddr(rank_raddr), .rdata(ra_rdata)
    );
    salb_ram #(.WIDTH(AW), .DEPTH(TEXT_DEPTH)) u_rank_b (
        .aclk(aclk), .we(rank_we && tgt_b), .waddr(rank_waddr), .wdata(rank_wdata),
        .raddr(rank_raddr), .rdata(rb_rdata)
    );
    salb_ram #(.WIDTH(LW), .DEPTH(TEXT_DEPTH)) u_lcp (
        .aclk(aclk), .we(lcp_we), .waddr(lcp_waddr), .wdata(lcp_wdata),
        .raddr(AW'(s_data.rank_index)), .rdata(lcp_rdata)
    );

    // Run bounds
    assign mid_sum = SW'(lo_reg) + width_reg;
    assign hi_sum  = SW'(lo_reg) + (width_reg << 1);

    // Status to the controller
    always_comb begin
        st.out_free = !m_valid_reg || m_ready;
        st.k_done   = k_reg >= n_reg;
        st.k_zero   = k_reg == '0;
        st.w_done   = width_reg >= SW'(n_reg);
        st.lo_done  = lo_reg >= n_reg;
        st.i_end    = i_reg >= mid_reg;
        st.j_end    = j_reg >= hi_reg;
        st.x_end    = x_sum >= SW'(n_reg);
        st.y_end    = y_sum >= SW'(n_reg);
        st.x_lt     = tx < ty;
        st.x_ne     = tx != ty;
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg       <= '0;
            ovf_reg     <= 1'b0;
            built_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (op)
                salb_pkg::OP_APPEND: begin
                    if (txt_we) begin
                        n_reg     <= n_reg + LW'(1);
                        built_reg <= 1'b0;
                    end else begin
                        ovf_reg <= 1'b1;
                    end
                end
                salb_pkg::OP_READ:
                    bad_reg <= !built_reg ||
                               (CW'(s_data.rank_index) >= CW'(n_reg));
                salb_pkg::OP_READ_OUT: begin
                    out_reg.suffix_pos <= bad_reg ? '0 : salb_pkg::POS_W'(src_rdata);
                    out_reg.lcp_len    <= bad_reg ? '0 : salb_pkg::LEN_W'(lcp_rdata);
                    out_reg.text_count <= salb_pkg::LEN_W'(n_reg);
                    out_reg.overflow   <= ovf_reg;
                    out_reg.bad_index  <= bad_reg;
                    m_valid_reg        <= 1'b1;
                end
                salb_pkg::OP_BUILD_START: begin
                    k_reg   <= '0;
                    sel_reg <= 1'b0;
                end
                salb_pkg::OP_INIT_STEP:  k_reg <= k_reg + LW'(1);
                salb_pkg::OP_PASS_START: width_reg <= SW'(1);
                salb_pkg::OP_RUN_START:  lo_reg <= '0;
                salb_pkg::OP_RUN_SETUP: begin
                    mid_reg <= (mid_sum < SW'(n_reg)) ? LW'(mid_sum) : n_reg;
                    hi_reg  <= (hi_sum < SW'(n_reg)) ? LW'(hi_sum) : n_reg;
                    j_reg   <= (mid_sum < SW'(n_reg)) ? LW'(mid_sum) : n_reg;
                    i_reg   <= lo_reg;
                    k_reg   <= lo_reg;
                end
                salb_pkg::OP_RUN_NEXT: lo_reg <= hi_reg;
                salb_pkg::OP_PASS_NEXT: begin
                    width_reg <= width_reg << 1;
                    sel_reg   <= ~sel_reg;
                end
                salb_pkg::OP_LATCH_X_RD_J, salb_pkg::OP_LATCH_X_RD_CUR: x_reg <= src_rdata;
                salb_pkg::OP_LATCH_Y: begin
                    y_reg <= src_rdata;
                    c_reg <= '0;
                end
                salb_pkg::OP_C_INC: c_reg <= c_reg + LW'(1);
                salb_pkg::OP_WR_X, salb_pkg::OP_CP_I: begin
                    i_reg <= i_reg + LW'(1);
                    k_reg <= k_reg + LW'(1);
                end
                salb_pkg::OP_WR_Y, salb_pkg::OP_CP_J: begin
                    j_reg <= j_reg + LW'(1);
                    k_reg <= k_reg + LW'(1);
                end
                salb_pkg::OP_LCP_START: k_reg <= '0;
                salb_pkg::OP_LCP_ZERO:  k_reg <= LW'(1);
                salb_pkg::OP_LCP_WR:    k_reg <= k_reg + LW'(1);
                salb_pkg::OP_BUILD_DONE: begin
                    built_reg          <= 1'b1;
                    out_reg.suffix_pos <= '0;
                    out_reg.lcp_len    <= '0;
                    out_reg.text_count <= salb_pkg::LEN_W'(n_reg);
                    out_reg.overflow   <= ovf_reg;
                    out_reg.bad_index  <= 1'b0;
                    m_valid_reg        <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Checks
    `SALB_ASSERT_NOW(a_len_cap, aclk, aresetn, 1'b1, SW'(n_reg) <= SW'(TEXT_DEPTH))
    `SALB_ASSERT_NOW(a_merge_in_run, aclk, aresetn,
        op == salb_pkg::OP_WR_X || op == salb_pkg::OP_WR_Y,
        i_reg < mid_reg && j_reg < hi_reg && k_reg < hi_reg)
    `SALB_ASSERT_NEXT(a_cmp_extends, aclk, aresetn, op == salb_pkg::OP_C_INC,
        c_reg != '0 && c_reg <= n_reg)
endmodule

// ===== tb/sv/tb_suffix_array_lcp_builder.sv =====
// Testbench for the suffix array and LCP builder: directed table, random requests, scoreboard.
module tb_suffix_array_lcp_builder;

    localparam int DEPTH       = 1024;
    localparam int RAND_ITEMS  = 2000;
    localparam int DRAIN_LIMIT = 2000000;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    salb_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    salb_pkg::out_item_t m_data;

    suffix_array_lcp_builder #(.TEXT_DEPTH(DEPTH)) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Shadow copy of the text and of the sorted arrays
    logic [7:0]  txt_mem [DEPTH];
    logic [9:0]  sa_mem  [DEPTH];
    logic [10:0] lcp_mem [DEPTH];
    int          txt_len;
    bit          ovf_seen;
    bit          sa_valid;

    salb_pkg::out_item_t pending_q[$];
    int          mismatch_cnt;
    int          result_cnt;
    int          build_cnt;
    int          read_cnt;
    bit          calm;

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    initial begin
        #1000000000;
        $display("timeout");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Length of the common prefix of the suffixes at a and b
    function automatic int common_len(int a, int b);
        int c;
        c = 0;
        while (a + c < txt_len && b + c < txt_len && txt_mem[a + c] == txt_mem[b + c])
            c++;
        return c;
    endfunction

    // Suffix a sorts before suffix b; a proper prefix comes first
    function automatic bit suffix_lt(int a, int b);
        int c;
        c = common_len(a, b);
        if (a + c >= txt_len) return 1'b1;
        if (b + c >= txt_len) return 1'b0;
        return txt_mem[a + c] < txt_mem[b + c];
    endfunction

    // Bottom-up merge sort of all suffixes, then direct LCP per rank
    task automatic sort_suffixes();
        int src [DEPTH];
        int dst [DEPTH];
        int w, lo, mid, hi, i, j, k;
        for (i = 0; i < txt_len; i++) src[i] = i;
        for (w = 1; w < txt_len; w = w * 2) begin
            for (lo = 0; lo < txt_len; lo = lo + 2 * w) begin
                mid = (lo + w < txt_len) ? lo + w : txt_len;
                hi  = (lo + 2 * w < txt_len) ? lo + 2 * w : txt_len;
                i = lo; j = mid; k = lo;
                while (i < mid || j < hi) begin
                    if (j >= hi || (i < mid && suffix_lt(src[i], src[j]))) begin
                        dst[k] = src[i]; i++;
                    end else begin
                        dst[k] = src[j]; j++;
                    end
                    k++;
                end
            end
            for (i = 0; i < txt_len; i++) src[i] = dst[i];
        end
        for (i = 0; i < txt_len; i++) begin
            sa_mem[i]  = 10'(src[i]);
            lcp_mem[i] = (i == 0) ? 11'd0 : 11'(common_len(src[i - 1], src[i]));
        end
    endtask

    // Update the shadow state for one accepted request and return its result
    task automatic predict_result(input salb_pkg::in_item_t req, output bit has_res,
                                  output salb_pkg::out_item_t res);
        res = '0;
        has_res = 1'b0;
        case (salb_pkg::func_t'(req.func))
            salb_pkg::FUNC_APPEND: begin
                if (txt_len < DEPTH) begin
                    txt_mem[txt_len] = req.text_byte;
                    txt_len++;
                    sa_valid = 1'b0;
                end else begin
                    ovf_seen = 1'b1;
                end
            end
            salb_pkg::FUNC_BUILD: begin
                sort_suffixes();
                sa_valid = 1'b1;
                has_res = 1'b1;
                build_cnt++;
            end
            salb_pkg::FUNC_READ: begin
                has_res = 1'b1;
                read_cnt++;
                if (!sa_valid || req.rank_index >= txt_len) begin
                    res.bad_index = 1'b1;
                end else begin
                    res.suffix_pos = sa_mem[req.rank_index];
                    res.lcp_len    = lcp_mem[req.rank_index];
                end
            end
            default: ;
        endcase
        res.text_count = 11'(txt_len);
        res.overflow   = ovf_seen;
    endtask

    // Present one request, hold it until accepted, queue its expectation
    task automatic send_request(input salb_pkg::in_item_t req, input bit typed,
                                input salb_pkg::out_item_t typed_res);
        bit                  has_res;
        salb_pkg::out_item_t res;
        while (!calm && $urandom_range(0, 99) < 25) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        predict_result(req, has_res, res);
        if (has_res) pending_q.insert(pending_q.size(), typed ? typed_res : res);
        @(negedge aclk);
    endtask

    // Result side: random stalls, compare against oldest expectation
    always @(negedge aclk) m_ready <= calm || ($urandom_range(0, 99) >= 25);

    always @(posedge aclk) begin
        salb_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            result_cnt++;
            if (pending_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected result %h", m_data);
            end else begin
                want = pending_q.pop_front();
                if (want.suffix_pos != m_data.suffix_pos || want.lcp_len != m_data.lcp_len
                    || want.text_count != m_data.text_count
                    || want.overflow != m_data.overflow
                    || want.bad_index != m_data.bad_index) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"result %0d: exp pos=%0d lcp=%0d cnt=%0d ovf=%0b bad=%0b,",
                                  " got pos=%0d lcp=%0d cnt=%0d ovf=%0b bad=%0b"},
                                 result_cnt, want.suffix_pos, want.lcp_len, want.text_count,
                                 want.overflow, want.bad_index, m_data.suffix_pos,
                                 m_data.lcp_len, m_data.text_count, m_data.overflow,
                                 m_data.bad_index);
                end
            end
        end
    end

    typedef struct {
        salb_pkg::func_t     fn;
        logic [7:0]          tb;
        logic [9:0]          rk;
        bit                  typed;
        salb_pkg::out_item_t res;
    } row_t;

    // fields of a typed result: pos, lcp, count, overflow, bad
    function automatic salb_pkg::out_item_t mk(int p, int l, int c, bit o, bit b);
        salb_pkg::out_item_t r;
        r = '{suffix_pos: 10'(p), lcp_len: 11'(l), text_count: 11'(c), overflow: o,
              bad_index: b};
        return r;
    endfunction

    initial begin
        row_t                rows[$];
        salb_pkg::in_item_t  req;
        salb_pkg::out_item_t none;
        int                  n, mode, waited, pick;
        none = '0;
        s_valid = 1'b0; s_data = '0; aresetn = 1'b0;
        txt_len = 0; ovf_seen = 0; sa_valid = 0; calm = 0;
        mismatch_cnt = 0; result_cnt = 0; build_cnt = 0; read_cnt = 0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: nothing built, empty build, two extreme bytes, bad ranks, unused code
        rows.insert(rows.size(), '{salb_pkg::FUNC_READ,   8'h00, 10'd0,    1'b1,
                                   mk(0, 0, 0, 0, 1)});
        rows.insert(rows.size(), '{salb_pkg::FUNC_BUILD,  8'h00, 10'd0,    1'b1,
                                   mk(0, 0, 0, 0, 0)});
        rows.insert(rows.size(), '{salb_pkg::FUNC_READ,   8'h00, 10'd0,    1'b1,
                                   mk(0, 0, 0, 0, 1)});
        rows.insert(rows.size(), '{salb_pkg::FUNC_APPEND, 8'h00, 10'd0,    1'b0, none});
        rows.insert(rows.size(), '{salb_pkg::FUNC_APPEND, 8'hFF, 10'd0,    1'b0, none});
        rows.insert(rows.size(), '{salb_pkg::FUNC_BUILD,  8'h00, 10'd0,    1'b1,
                                   mk(0, 0, 2, 0, 0)});
        rows.insert(rows.size(), '{salb_pkg::FUNC_READ,   8'h00, 10'd0,    1'b1,
                                   mk(0, 0, 2, 0, 0)});
        rows.insert(rows.size(), '{salb_pkg::FUNC_READ,   8'h00, 10'd1,    1'b1,
                                   mk(1, 0, 2, 0, 0)});
        rows.insert(rows.size(), '{salb_pkg::FUNC_READ,   8'h00, 10'd2,    1'b1,
                                   mk(0, 0, 2, 0, 1)});
        rows.insert(rows.size(), '{salb_pkg::FUNC_READ,   8'h00, 10'd1023, 1'b1,
                                   mk(0, 0, 2, 0, 1)});
        rows.insert(rows.size(), '{salb_pkg::FUNC_NOP,    8'hA5, 10'd5,    1'b0, none});
        rows.insert(rows.size(), '{salb_pkg::FUNC_APPEND, 8'hFF, 10'd0,    1'b0, none});
        rows.insert(rows.size(), '{salb_pkg::FUNC_READ,   8'h00, 10'd0,    1'b1,
                                   mk(0, 0, 3, 0, 1)});
        rows.insert(rows.size(), '{salb_pkg::FUNC_APPEND, 8'hFF, 10'd0,    1'b0, none});
        rows.insert(rows.size(), '{salb_pkg::FUNC_APPEND, 8'hFF, 10'd0,    1'b0, none});
        rows.insert(rows.size(), '{salb_pkg::FUNC_BUILD,  8'h00, 10'd0,    1'b1,
                                   mk(0, 0, 5, 0, 0)});
        for (int r = 0; r < 5; r++)
            rows.insert(rows.size(), '{salb_pkg::FUNC_READ, 8'h00, 10'(r), 1'b0, none});
        foreach (rows[i]) begin
            req.func = rows[i].fn; req.text_byte = rows[i].tb; req.rank_index = rows[i].rk;
            send_request(req, rows[i].typed, rows[i].res);
        end

        // Random: texts mostly over narrow alphabets for long shared prefixes, builds, reads, unused codes
        mode = 0;
        for (n = 0; n < RAND_ITEMS; n++) begin
            calm = (n >= 900 && n < 1200);
            req.text_byte  = 8'($urandom);
            req.rank_index = 10'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                req.func = salb_pkg::FUNC_APPEND;
                if (mode == 0) req.text_byte = 8'(8'h61 + $urandom_range(0, 1));
                else if (mode == 1) req.text_byte = 8'h7A;
                else if (mode == 2) req.text_byte = 8'($urandom_range(0, 3) * 8'h55);
            end else if (pick < 58) begin
                req.func = salb_pkg::FUNC_BUILD;
                mode = $urandom_range(0, 3);
            end else if (pick < 60) begin
                req.func = salb_pkg::FUNC_NOP;
            end else begin
                req.func = salb_pkg::FUNC_READ;
                if ($urandom_range(0, 9) != 0) req.rank_index = 10'($urandom_range(0, txt_len));
            end
            send_request(req, 1'b0, none);
        end
        // Last build over the full text, then reads up to the top rank
        req.func = salb_pkg::FUNC_BUILD;
        send_request(req, 1'b0, none);
        for (n = 0; n < 20; n++) begin
            req.func = salb_pkg::FUNC_READ;
            req.rank_index = (n == 0) ? 10'd1023 : 10'($urandom_range(0, 1023));
            send_request(req, 1'b0, none);
        end
        s_valid <= 1'b0;

        waited = 0;
        while (pending_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (20) @(posedge aclk);
        $display("covered %0d builds and %0d reads, final text %0d bytes, overflow %0b",
                 build_cnt, read_cnt, txt_len, ovf_seen);
        $display("%0d results checked, %0d mismatches, %0d left pending",
                 result_cnt, mismatch_cnt, pending_q.size());
        if (mismatch_cnt == 0 && pending_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
